### hdl/lec_pkg.sv
// Shared types, constants and arithmetic helpers for the level-set edge crossing block.
package lec_pkg;

    localparam int unsigned GRID_NX = 256;
    localparam int unsigned GRID_NY = 256;
    localparam int unsigned GRID_NZ = 256;

    // One quotient bit per divider stage; quotients stay below 2^33
    localparam int unsigned DIV_STEPS = 33;

    localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_MIN = 32'h8000_0000;

    typedef enum logic [2:0] {
        CFG_ORIGIN_X  = 3'd0,
        CFG_ORIGIN_Y  = 3'd1,
        CFG_ORIGIN_Z  = 3'd2,
        CFG_SPACING_X = 3'd3,
        CFG_SPACING_Y = 3'd4,
        CFG_SPACING_Z = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2,
        AXIS_NONE = 2'd3
    } t_axis;

    typedef struct packed {
        logic [7:0]  cell_i;
        logic [7:0]  cell_j;
        logic [7:0]  cell_k;
        logic [1:0]  edge_axis;
        logic [31:0] level_here;
        logic [31:0] level_next;
        logic [31:0] grad_here_x;
        logic [31:0] grad_here_y;
        logic [31:0] grad_here_z;
        logic [31:0] grad_next_x;
        logic [31:0] grad_next_y;
        logic [31:0] grad_next_z;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  face_axis;
        logic [7:0]  face_i;
        logic [7:0]  face_j;
        logic [7:0]  face_k;
        logic [31:0] cross_x;
        logic [31:0] cross_y;
        logic [31:0] cross_z;
        logic [31:0] normal_x;
        logic [31:0] normal_y;
        logic [31:0] normal_z;
    } t_out_item;

    typedef struct packed {
        logic [30:0] h_x;
        logic [30:0] h_y;
        logic [30:0] h_z;
    } t_spacing;

    // Partial remainder and shifting dividend/quotient word of one divider lane
    typedef struct packed {
        logic [33:0] rem;
        logic [32:0] word;
    } t_lane;

    // Sideband that travels with each item through the divider
    typedef struct packed {
        logic [1:0]        axis;
        logic [2:0][7:0]   face;
        logic [2:0][40:0]  base;
        logic [2:0][31:0]  gh;
        logic [2:0]        neg;
        logic [33:0]       div_c;
        logic [33:0]       div_n;
    } t_side;

    typedef struct packed {
        t_side            side;
        t_lane [3:0]      lane;   // lane 0 crossing, lanes 1..3 normal x/y/z
    } t_div;

    // One restoring step: bring in the next dividend bit, subtract if it fits
    function automatic t_lane div_step(t_lane x, logic [33:0] d);
        logic [34:0] t;
        logic [34:0] s;
        t_lane       y;
        t = {x.rem, x.word[32]};
        s = t - {1'b0, d};
        if (t >= {1'b0, d}) begin
            y.rem  = s[33:0];
            y.word = {x.word[31:0], 1'b1};
        end else begin
            y.rem  = t[33:0];
            y.word = {x.word[31:0], 1'b0};
        end
        return y;
    endfunction

    function automatic logic [31:0] sat32(logic [41:0] v);
        logic [31:0] r;
        if (!v[41] && (v[40:31] != 10'd0)) begin
            r = SAT_MAX;
        end else if (v[41] && (v[40:31] != 10'h3FF)) begin
            r = SAT_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

### hdl/lec_if.sv
// Streaming channel interfaces: edge items in, Hermite results out.
interface lec_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  cell_i;
    logic [7:0]  cell_j;
    logic [7:0]  cell_k;
    logic [1:0]  edge_axis;
    logic [31:0] level_here;
    logic [31:0] level_next;
    logic [31:0] grad_here_x;
    logic [31:0] grad_here_y;
    logic [31:0] grad_here_z;
    logic [31:0] grad_next_x;
    logic [31:0] grad_next_y;
    logic [31:0] grad_next_z;

    modport source (output valid, cell_i, cell_j, cell_k, edge_axis, level_here, level_next,
                    grad_here_x, grad_here_y, grad_here_z, grad_next_x, grad_next_y,
                    grad_next_z, input ready);
    modport sink (input valid, cell_i, cell_j, cell_k, edge_axis, level_here, level_next,
                  grad_here_x, grad_here_y, grad_here_z, grad_next_x, grad_next_y,
                  grad_next_z, output ready);
endinterface

interface lec_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  face_axis;
    logic [7:0]  face_i;
    logic [7:0]  face_j;
    logic [7:0]  face_k;
    logic [31:0] cross_x;
    logic [31:0] cross_y;
    logic [31:0] cross_z;
    logic [31:0] normal_x;
    logic [31:0] normal_y;
    logic [31:0] normal_z;

    modport source (output valid, face_axis, face_i, face_j, face_k, cross_x, cross_y,
                    cross_z, normal_x, normal_y, normal_z, input ready);
    modport sink (input valid, face_axis, face_i, face_j, face_k, cross_x, cross_y,
                  cross_z, normal_x, normal_y, normal_z, output ready);
endinterface

### hdl/lec_front.sv
// Front end: edge checks, magnitudes, products and divider operand set-up (three stages).
module lec_front import lec_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  logic     i_valid,
    input  t_in_item i_item,
    input  t_spacing i_spacing,
    output logic     o_valid,
    output t_div     o_div
);

    // stage 1 registers
    logic              r1_valid, n1_valid;
    logic [1:0]        r1_axis, n1_axis;
    logic [2:0][7:0]   r1_face, n1_face;
    logic [2:0][8:0]   r1_q, n1_q;
    logic [32:0]       r1_mt, n1_mt;
    logic [32:0]       r1_mh, n1_mh;
    logic [33:0]       r1_r, n1_r;
    logic [2:0][32:0]  r1_md, n1_md;
    logic [2:0]        r1_neg, n1_neg;
    logic [2:0][31:0]  r1_gh, n1_gh;

    // stage 2 registers
    logic              r2_valid;
    logic [1:0]        r2_axis;
    logic [2:0][7:0]   r2_face;
    logic [32:0]       r2_mt;
    logic [64:0]       r2_pc, n2_pc;
    logic [2:0][65:0]  r2_pn, n2_pn;
    logic [2:0][39:0]  r2_bq, n2_bq;
    logic [2:0]        r2_neg;
    logic [2:0][31:0]  r2_gh;

    // stage 3 registers
    logic              r3_valid;
    t_div              r3_div, n3_div;

    logic [2:0][30:0]  w_h;
    assign w_h = {i_spacing.h_z, i_spacing.h_y, i_spacing.h_x};

    always_comb begin
        logic [2:0][7:0]  idx;
        logic [2:0][31:0] gh;
        logic [2:0][31:0] gn;
        logic [32:0]      lh, ln, diff, dg;
        logic [34:0]      s, two_mt, sr;
        logic [7:0]       idx_ax;
        logic [8:0]       lim_ax;
        logic             ge, ok;
        idx = {i_item.cell_k, i_item.cell_j, i_item.cell_i};
        gh  = {i_item.grad_here_z, i_item.grad_here_y, i_item.grad_here_x};
        gn  = {i_item.grad_next_z, i_item.grad_next_y, i_item.grad_next_x};
        lh   = {i_item.level_here[31], i_item.level_here};
        ln   = {i_item.level_next[31], i_item.level_next};
        diff = ln - lh;
        n1_mt = diff[32] ? (33'd0 - diff) : diff;
        n1_mh = lh[32] ? (33'd0 - lh) : lh;
        s      = {2'b00, n1_mt} + {1'b0, n1_mh, 1'b0};
        two_mt = {1'b0, n1_mt, 1'b0};
        ge     = (s >= two_mt);
        sr     = ge ? (s - two_mt) : s;
        n1_r   = sr[33:0];
        n1_axis = i_item.edge_axis;
        case (t_axis'(i_item.edge_axis))
            AXIS_X: begin idx_ax = idx[0]; lim_ax = 9'(GRID_NX); end
            AXIS_Y: begin idx_ax = idx[1]; lim_ax = 9'(GRID_NY); end
            AXIS_Z: begin idx_ax = idx[2]; lim_ax = 9'(GRID_NZ); end
            default: begin idx_ax = 8'd0; lim_ax = 9'd0; end
        endcase
        ok = (t_axis'(i_item.edge_axis) != AXIS_NONE)
             && ({1'b0, idx[0]} < 9'(GRID_NX))
             && ({1'b0, idx[1]} < 9'(GRID_NY))
             && ({1'b0, idx[2]} < 9'(GRID_NZ))
             && (({1'b0, idx_ax} + 9'd1) < lim_ax)
             && (i_item.level_here[31] != i_item.level_next[31]);
        n1_valid = i_valid && ok;
        for (int a = 0; a < 3; a++) begin
            n1_face[a] = idx[a] + 8'((i_item.edge_axis == 2'(a)) ? 1 : 0);
            n1_q[a]    = {1'b0, idx[a]}
                         + 9'(((i_item.edge_axis == 2'(a)) && ge) ? 1 : 0);
            dg         = {gn[a][31], gn[a]} - {gh[a][31], gh[a]};
            n1_neg[a]  = dg[32];
            n1_md[a]   = dg[32] ? (33'd0 - dg) : dg;
            n1_gh[a]   = gh[a];
        end
    end

    always_comb begin
        logic [30:0] h_ax;
        case (t_axis'(r1_axis))
            AXIS_X:  h_ax = w_h[0];
            AXIS_Y:  h_ax = w_h[1];
            AXIS_Z:  h_ax = w_h[2];
            default: h_ax = 31'd0;
        endcase
        n2_pc = {34'd0, h_ax} * {31'd0, r1_r};
        for (int a = 0; a < 3; a++) begin
            n2_pn[a] = {33'd0, r1_md[a]} * {33'd0, r1_mh};
            n2_bq[a] = {9'd0, w_h[a]} * {31'd0, r1_q[a]};
        end
    end

    always_comb begin
        logic [65:0] nc, nn;
        logic [31:0] half;
        nc = {1'b0, r2_pc} + {33'd0, r2_mt};
        n3_div.side.axis  = r2_axis;
        n3_div.side.face  = r2_face;
        n3_div.side.gh    = r2_gh;
        n3_div.side.neg   = r2_neg;
        n3_div.side.div_c = {r2_mt, 1'b0};
        n3_div.side.div_n = {1'b0, r2_mt};
        n3_div.lane[0].rem  = {1'b0, nc[65:33]};
        n3_div.lane[0].word = nc[32:0];
        for (int a = 0; a < 3; a++) begin
            nn   = r2_pn[a] + {34'd0, r2_mt[32:1]};
            half = ({1'b0, w_h[a]} + 32'd1) >> 1;
            n3_div.lane[a+1].rem  = {1'b0, nn[65:33]};
            n3_div.lane[a+1].word = nn[32:0];
            // off-axis centres sit half a cell in; the edge axis gets its fraction later
            n3_div.side.base[a] = {1'b0, r2_bq[a]}
                                  + ((r2_axis == 2'(a)) ? 41'd0 : {10'd0, half[30:0]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= n1_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_axis <= n1_axis;
            r1_face <= n1_face;
            r1_q    <= n1_q;
            r1_mt   <= n1_mt;
            r1_mh   <= n1_mh;
            r1_r    <= n1_r;
            r1_md   <= n1_md;
            r1_neg  <= n1_neg;
            r1_gh   <= n1_gh;
            r2_axis <= r1_axis;
            r2_face <= r1_face;
            r2_mt   <= r1_mt;
            r2_pc   <= n2_pc;
            r2_pn   <= n2_pn;
            r2_bq   <= n2_bq;
            r2_neg  <= r1_neg;
            r2_gh   <= r1_gh;
            r3_div  <= n3_div;
        end
    end

    assign o_valid = r3_valid;
    assign o_div   = r3_div;

endmodule

### hdl/lec_divider.sv
// Pipelined restoring divider: four lanes, two divisors, one quotient bit per stage.
module lec_divider import lec_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_div i_div,
    output logic o_valid,
    output t_div o_div
);

    logic [DIV_STEPS-1:0] r_valid;
    t_div                 r_div [DIV_STEPS];

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
        t_div w_prev;
        t_div n_div;
        logic w_pv;
        if (g == 0) begin : g_first
            assign w_prev = i_div;
            assign w_pv   = i_valid;
        end else begin : g_rest
            assign w_prev = r_div[g-1];
            assign w_pv   = r_valid[g-1];
        end

        always_comb begin
            n_div.side    = w_prev.side;
            n_div.lane[0] = div_step(w_prev.lane[0], w_prev.side.div_c);
            for (int l = 1; l < 4; l++) begin
                n_div.lane[l] = div_step(w_prev.lane[l], w_prev.side.div_n);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g] <= 1'b0;
            end else if (i_en) begin
                r_valid[g] <= w_pv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_div[g] <= n_div;
            end
        end
    end

    assign o_valid = r_valid[DIV_STEPS-1];
    assign o_div   = r_div[DIV_STEPS-1];

endmodule

### hdl/lec_back.sv
// Back end: final sums, saturation and the output register with its stall control.
module lec_back import lec_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  t_div            i_div,
    input  logic [2:0][31:0] i_origin,
    input  logic            i_ready,
    output logic            o_en,
    output logic            o_valid,
    output t_out_item       o_item
);

    logic      r_valid;
    t_out_item r_item, n_item;

    always_comb begin
        logic [2:0][31:0] cr, nr;
        logic [41:0]      sum;
        logic [34:0]      nsum;
        logic [32:0]      qc;
        qc = i_div.lane[0].word;
        for (int a = 0; a < 3; a++) begin
            sum = {{10{i_origin[a][31]}}, i_origin[a]} + {1'b0, i_div.side.base[a]}
                  + ((i_div.side.axis == 2'(a)) ? {9'd0, qc} : 42'd0);
            cr[a] = sat32(sum);
            nsum = i_div.side.neg[a]
                   ? ({{3{i_div.side.gh[a][31]}}, i_div.side.gh[a]}
                      - {2'b00, i_div.lane[a+1].word})
                   : ({{3{i_div.side.gh[a][31]}}, i_div.side.gh[a]}
                      + {2'b00, i_div.lane[a+1].word});
            nr[a] = sat32({{7{nsum[34]}}, nsum});
        end
        n_item.face_axis = i_div.side.axis;
        n_item.face_i    = i_div.side.face[0];
        n_item.face_j    = i_div.side.face[1];
        n_item.face_k    = i_div.side.face[2];
        n_item.cross_x   = cr[0];
        n_item.cross_y   = cr[1];
        n_item.cross_z   = cr[2];
        n_item.normal_x  = nr[0];
        n_item.normal_y  = nr[1];
        n_item.normal_z  = nr[2];
    end

    // advance the whole pipe unless a held result is still waiting
    assign o_en = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### hdl/levelset_edge_crossing_hermite_top.sv
// Top level of the level-set edge crossing block (Hermite data for dual contouring).
//
// Usage
//   i_in  : one grid edge per transaction (cell index, axis, two level values,
//           two gradients), valid/ready handshake.
//   o_out : one Hermite sample per crossing edge (face index, crossing point,
//           interpolated normal). Edges that leave the grid, carry an unused
//           axis code or do not change sign produce no transaction at all.
//   cfg   : plain write port, i_cfg_we/i_cfg_idx/i_cfg_data; indices 0..2 are
//           the origin, 3..5 the spacing. Write only while the block is idle.
// Throughput: one edge per cycle, sustained while no result is held with o_out.ready low.
// Pipeline: three front stages (checks, multipliers, operand set-up), 33
//   divider stages (one quotient bit each, all four quotients in parallel)
//   and the output register lie between the input transaction and o_out.valid.
// Reset: synchronous, active low; empties the pipe and loads origin 0 and
//   spacing 1.0.
// Stall: while a result is held with o_out.ready low the whole pipe holds and
//   i_in.ready drops; nothing is lost or repeated. A free output register keeps
//   i_in.ready high even while items are in flight.
module levelset_edge_crossing_hermite_top import lec_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lec_in_if.sink      i_in,
    lec_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    logic [2:0][31:0] r_origin;
    t_spacing         r_spacing;

    logic      w_en;
    t_in_item  w_item;
    logic      w_front_valid, w_div_valid;
    t_div      w_front_div, w_div_out;
    t_out_item w_out;

    // hold configuration; unknown indices are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin  <= '0;
            r_spacing <= '{h_x: 31'd65536, h_y: 31'd65536, h_z: 31'd65536};
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ORIGIN_X:  r_origin[0]   <= i_cfg_data;
                CFG_ORIGIN_Y:  r_origin[1]   <= i_cfg_data;
                CFG_ORIGIN_Z:  r_origin[2]   <= i_cfg_data;
                CFG_SPACING_X: r_spacing.h_x <= i_cfg_data[30:0];
                CFG_SPACING_Y: r_spacing.h_y <= i_cfg_data[30:0];
                CFG_SPACING_Z: r_spacing.h_z <= i_cfg_data[30:0];
                default: begin
                end
            endcase
        end
    end

    assign w_item = '{
        cell_i: i_in.cell_i, cell_j: i_in.cell_j, cell_k: i_in.cell_k,
        edge_axis: i_in.edge_axis,
        level_here: i_in.level_here, level_next: i_in.level_next,
        grad_here_x: i_in.grad_here_x, grad_here_y: i_in.grad_here_y,
        grad_here_z: i_in.grad_here_z, grad_next_x: i_in.grad_next_x,
        grad_next_y: i_in.grad_next_y, grad_next_z: i_in.grad_next_z};

    assign i_in.ready = w_en;

    lec_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (i_in.valid),
        .i_item    (w_item),
        .i_spacing (r_spacing),
        .o_valid   (w_front_valid),
        .o_div     (w_front_div)
    );

    lec_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_front_valid),
        .i_div   (w_front_div),
        .o_valid (w_div_valid),
        .o_div   (w_div_out)
    );

    lec_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_div_valid),
        .i_div    (w_div_out),
        .i_origin (r_origin),
        .i_ready  (o_out.ready),
        .o_en     (w_en),
        .o_valid  (o_out.valid),
        .o_item   (w_out)
    );

    assign o_out.face_axis = w_out.face_axis;
    assign o_out.face_i    = w_out.face_i;
    assign o_out.face_j    = w_out.face_j;
    assign o_out.face_k    = w_out.face_k;
    assign o_out.cross_x   = w_out.cross_x;
    assign o_out.cross_y   = w_out.cross_y;
    assign o_out.cross_z   = w_out.cross_z;
    assign o_out.normal_x  = w_out.normal_x;
    assign o_out.normal_y  = w_out.normal_y;
    assign o_out.normal_z  = w_out.normal_z;

    // a held result must stall the input side
    a_stall_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |-> !i_in.ready)
        else $error("input accepted while output stalled");

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("result present after reset");

    // only real axes reach the output
    a_axis_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.face_axis != AXIS_NONE))
        else $error("unused axis code emitted");

    // the face index is one past the cell on the edge axis, so never zero there; checked on x
    a_face_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.face_axis == AXIS_X)) |-> (o_out.face_i != 8'd0))
        else $error("face index not advanced on edge axis");

endmodule

### test/levelset_edge_crossing_hermite_top_tb.sv
// Self-checking testbench for the level-set edge crossing block.
module levelset_edge_crossing_hermite_top_tb import lec_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LATENCY     = 37;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned N_RANDOM    = 800;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [2:0] i_cfg_idx;
    logic [31:0] i_cfg_data;

    lec_in_if  edge_ch ();
    lec_out_if hermite_ch ();

    levelset_edge_crossing_hermite_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (edge_ch),
        .o_out      (hermite_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow copy of the block's configuration registers, kept by write_reg for the predictor
    logic signed [31:0] origin_sh [3];
    logic [30:0] spacing_sh [3];

    t_out_item hermite_expected [$];
    int unsigned fail_count;
    int unsigned edges_sent;
    int unsigned hermites_seen;
    int unsigned cycle_count;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    // Directed table row: an edge and, where it is obvious, the Hermite sample
    typedef struct {
        t_in_item  edge_item;
        bit        has_fixed;
        bit        fixed_emits;
        t_out_item fixed_out;
    } t_edge_row;

    t_edge_row edge_table [$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Saturate a wide signed value to Q16.16
    function automatic logic [31:0] clamp_q16(logic signed [71:0] v);
        if (v > 72'sd2147483647) begin
            return SAT_MAX;
        end
        if (v < -72'sd2147483648) begin
            return SAT_MIN;
        end
        return v[31:0];
    endfunction

    // h * num / den, rounded half up; same split as the block to stay exact
    function automatic logic [71:0] spaced_offset(logic [30:0] h, logic [71:0] num,
                                                  logic [71:0] den);
        logic [71:0] q;
        logic [71:0] r;
        q = num / den;
        r = num % den;
        return 72'(h) * q + (72'(h) * r + den / 2) / den;
    endfunction

    // Predict the Hermite sample for one edge; returns 0 when the edge is skipped
    function automatic bit predict_hermite(t_in_item e, output t_out_item o);
        logic [7:0] idx [3];
        int unsigned lim [3];
        logic signed [71:0] lh;
        logic signed [71:0] ln;
        logic signed [71:0] gh;
        logic signed [71:0] gn;
        logic signed [71:0] d;
        logic [71:0] mag_t;
        logic [71:0] mag_h;
        logic [71:0] md;
        logic [71:0] m;
        logic [71:0] off;
        logic [31:0] gh_w [3];
        logic [31:0] gn_w [3];
        logic [31:0] cr [3];
        logic [31:0] nr [3];
        o = '0;
        idx[0] = e.cell_i;
        idx[1] = e.cell_j;
        idx[2] = e.cell_k;
        lim = '{GRID_NX, GRID_NY, GRID_NZ};
        if (e.edge_axis == AXIS_NONE) begin
            return 1'b0;
        end
        for (int a = 0; a < 3; a++) begin
            if (32'(idx[a]) >= lim[a]) begin
                return 1'b0;
            end
        end
        if (32'(idx[e.edge_axis]) + 1 >= lim[e.edge_axis]) begin
            return 1'b0;
        end
        lh = 72'(signed'(e.level_here));
        ln = 72'(signed'(e.level_next));
        if ((lh < 0) == (ln < 0)) begin
            return 1'b0;
        end
        d = ln - lh;
        mag_t = d < 0 ? -d : d;
        mag_h = lh < 0 ? -lh : lh;
        for (int a = 0; a < 3; a++) begin
            if (a == e.edge_axis) begin
                off = spaced_offset(spacing_sh[a], (2 * 72'(idx[a]) + 1) * mag_t + 2 * mag_h,
                                    2 * mag_t);
            end else begin
                off = spaced_offset(spacing_sh[a], 2 * 72'(idx[a]) + 1, 72'd2);
            end
            cr[a] = clamp_q16(72'(origin_sh[a]) + signed'(off));
        end
        gh_w = '{e.grad_here_x, e.grad_here_y, e.grad_here_z};
        gn_w = '{e.grad_next_x, e.grad_next_y, e.grad_next_z};
        for (int a = 0; a < 3; a++) begin
            gh = 72'(signed'(gh_w[a]));
            gn = 72'(signed'(gn_w[a]));
            d = gn - gh;
            md = d < 0 ? -d : d;
            m = (md * mag_h + mag_t / 2) / mag_t;
            nr[a] = clamp_q16(d < 0 ? gh - signed'(m) : gh + signed'(m));
        end
        o.face_axis = e.edge_axis;
        o.face_i = idx[0] + 8'(e.edge_axis == AXIS_X);
        o.face_j = idx[1] + 8'(e.edge_axis == AXIS_Y);
        o.face_k = idx[2] + 8'(e.edge_axis == AXIS_Z);
        {o.cross_x, o.cross_y, o.cross_z} = {cr[0], cr[1], cr[2]};
        {o.normal_x, o.normal_y, o.normal_z} = {nr[0], nr[1], nr[2]};
        return 1'b1;
    endfunction

    function automatic t_in_item random_edge();
        t_in_item e;
        logic [319:0] raw;
        int unsigned pick;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom};
        e = raw[281:0];
        pick = $urandom_range(0, 9);
        // Mostly crossing edges at sane magnitudes so the arithmetic is exercised
        if (pick < 7) begin
            e.edge_axis = t_axis'($urandom_range(0, 2));
            e.level_here = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h7FFFF);
            e.level_next = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h7FFFF);
            e.level_next[31] = ~e.level_here[31];
            if (pick < 4) begin
                e.cell_i = $urandom_range(0, 254);
                e.cell_j = $urandom_range(0, 254);
                e.cell_k = $urandom_range(0, 254);
            end
        end
        return e;
    endfunction

    // Hold the edge until the block accepts it; gaps come from send_idle_pct
    task automatic send_edge(t_in_item e);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            edge_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        edge_ch.valid       <= 1'b1;
        edge_ch.cell_i      <= e.cell_i;
        edge_ch.cell_j      <= e.cell_j;
        edge_ch.cell_k      <= e.cell_k;
        edge_ch.edge_axis   <= e.edge_axis;
        edge_ch.level_here  <= e.level_here;
        edge_ch.level_next  <= e.level_next;
        edge_ch.grad_here_x <= e.grad_here_x;
        edge_ch.grad_here_y <= e.grad_here_y;
        edge_ch.grad_here_z <= e.grad_here_z;
        edge_ch.grad_next_x <= e.grad_next_x;
        edge_ch.grad_next_y <= e.grad_next_y;
        edge_ch.grad_next_z <= e.grad_next_z;
        do begin
            @(posedge i_clk);
        end while (!edge_ch.ready);
        edges_sent++;
    endtask

    task automatic send_and_predict(t_in_item e);
        t_out_item o;
        if (predict_hermite(e, o)) begin
            hermite_expected.push_back(o);
        end
        send_edge(e);
    endtask

    // Drop valid, wait for the pipe to drain, then let skipped edges clear the divider
    task automatic drain_pipe();
        edge_ch.valid <= 1'b0;
        wait (hermite_expected.size() == 0);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx <= CFG_ORIGIN_Z) begin
            origin_sh[idx] = data;
        end else begin
            spacing_sh[idx - CFG_SPACING_X] = data[30:0];
        end
    endtask

    task automatic random_burst(int unsigned n);
        for (int unsigned i = 0; i < n; i++) begin
            send_and_predict(random_edge());
        end
    endtask

    function automatic t_edge_row mk_row(logic [7:0] ci, logic [7:0] cj, logic [7:0] ck,
                                         t_axis ax, logic [31:0] lh, logic [31:0] ln,
                                         logic [31:0] g);
        t_edge_row r;
        r.edge_item = {ci, cj, ck, ax, lh, ln, g, g, g, g, g, g};
        r.has_fixed = 1'b0;
        r.fixed_emits = 1'b0;
        r.fixed_out = '0;
        return r;
    endfunction

    function automatic t_edge_row mk_skip(logic [7:0] ci, logic [7:0] cj, logic [7:0] ck,
                                          t_axis ax, logic [31:0] lh, logic [31:0] ln);
        t_edge_row r;
        r = mk_row(ci, cj, ck, ax, lh, ln, 32'h0001_0000);
        r.has_fixed = 1'b1;
        return r;
    endfunction

    task automatic build_table();
        t_edge_row r;
        // Cell 0 on x, level -1 to +1, unit spacing: crossing at 1.0, normal = gradient
        r = mk_row(8'd0, 8'd0, 8'd0, AXIS_X, 32'hFFFF_0000, 32'h0001_0000, 32'h0002_0000);
        r.has_fixed = 1'b1;
        r.fixed_emits = 1'b1;
        r.fixed_out = {AXIS_X, 8'd1, 8'd0, 8'd0, 32'h0001_0000, 32'h0000_8000,
                       32'h0000_8000, 32'h0002_0000, 32'h0002_0000, 32'h0002_0000};
        edge_table.push_back(r);
        // Neighbour off the grid on each axis
        edge_table.push_back(mk_skip(8'd255, 8'd3, 8'd3, AXIS_X, 32'hFFFF_0000, 32'd5));
        edge_table.push_back(mk_skip(8'd3, 8'd255, 8'd3, AXIS_Y, 32'hFFFF_0000, 32'd5));
        edge_table.push_back(mk_skip(8'd3, 8'd3, 8'd255, AXIS_Z, 32'hFFFF_0000, 32'd5));
        // Unused axis code
        edge_table.push_back(mk_skip(8'd3, 8'd3, 8'd3, AXIS_NONE, 32'hFFFF_0000, 32'd5));
        // Same sign, zero counts with positive
        edge_table.push_back(mk_skip(8'd3, 8'd3, 8'd3, AXIS_X, 32'd0, 32'h7FFF_FFFF));
        edge_table.push_back(mk_skip(8'd3, 8'd3, 8'd3, AXIS_Y, 32'h8000_0000, 32'hFFFF_FFFF));
        // Predicted rows: zero on one side, extreme levels and gradients, last cells
        edge_table.push_back(mk_row(8'd254, 8'd255, 8'd255, AXIS_X, 32'd0, 32'hFFFF_FFFF,
                                    32'h7FFF_FFFF));
        edge_table.push_back(mk_row(8'd255, 8'd254, 8'd255, AXIS_Y, 32'h8000_0000,
                                    32'h7FFF_FFFF, 32'h8000_0000));
        edge_table.push_back(mk_row(8'd255, 8'd255, 8'd254, AXIS_Z, 32'h7FFF_FFFF,
                                    32'h8000_0000, 32'hAAAA_5555));
        edge_table.push_back(mk_row(8'd17, 8'd200, 8'd0, AXIS_Z, 32'hFFFF_FFFF, 32'd1,
                                    32'h5555_AAAA));
        r = mk_row(8'd9, 8'd9, 8'd9, AXIS_Y, 32'hFFF0_0000, 32'h0000_0001, 32'h0);
        r.edge_item.grad_here_x = 32'h7FFF_FFFF;
        r.edge_item.grad_next_x = 32'h8000_0000;
        r.edge_item.grad_here_y = 32'h8000_0000;
        r.edge_item.grad_next_y = 32'h7FFF_FFFF;
        edge_table.push_back(r);
    endtask

    // Typed-in samples hold only at reset settings; otherwise trust the predictor
    task automatic run_table(bit use_fixed);
        t_out_item o;
        bit emits;
        foreach (edge_table[n]) begin
            emits = predict_hermite(edge_table[n].edge_item, o);
            if (use_fixed && edge_table[n].has_fixed) begin
                if (emits != edge_table[n].fixed_emits) begin
                    $error("row %0d emits expected %0b actual %0b", n,
                           edge_table[n].fixed_emits, emits);
                    fail_count++;
                end
                if (edge_table[n].fixed_emits) begin
                    o = edge_table[n].fixed_out;
                end
            end
            if (emits) begin
                hermite_expected.push_back(o);
            end
            send_edge(edge_table[n].edge_item);
        end
    endtask

    // Receiver: random back-pressure on ready
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hermite_ch.ready <= 1'b0;
        end else begin
            hermite_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Compare every accepted sample with the oldest prediction
    always @(posedge i_clk) begin
        t_out_item got;
        t_out_item want;
        if (i_rst_n && hermite_ch.valid && hermite_ch.ready) begin
            got = {hermite_ch.face_axis, hermite_ch.face_i, hermite_ch.face_j,
                   hermite_ch.face_k, hermite_ch.cross_x, hermite_ch.cross_y,
                   hermite_ch.cross_z, hermite_ch.normal_x, hermite_ch.normal_y,
                   hermite_ch.normal_z};
            hermites_seen++;
            if (hermite_expected.size() == 0) begin
                $error("unexpected Hermite transaction face %0d,%0d,%0d",
                       got.face_i, got.face_j, got.face_k);
                fail_count++;
            end else begin
                want = hermite_expected.pop_front();
                if (got.face_axis != want.face_axis) begin
                    $error("face_axis expected %0d actual %0d", want.face_axis, got.face_axis);
                    fail_count++;
                end
                if (got.face_i != want.face_i) begin
                    $error("face_i expected %0d actual %0d", want.face_i, got.face_i);
                    fail_count++;
                end
                if (got.face_j != want.face_j) begin
                    $error("face_j expected %0d actual %0d", want.face_j, got.face_j);
                    fail_count++;
                end
                if (got.face_k != want.face_k) begin
                    $error("face_k expected %0d actual %0d", want.face_k, got.face_k);
                    fail_count++;
                end
                if (got.cross_x != want.cross_x) begin
                    $error("cross_x expected %h actual %h", want.cross_x, got.cross_x);
                    fail_count++;
                end
                if (got.cross_y != want.cross_y) begin
                    $error("cross_y expected %h actual %h", want.cross_y, got.cross_y);
                    fail_count++;
                end
                if (got.cross_z != want.cross_z) begin
                    $error("cross_z expected %h actual %h", want.cross_z, got.cross_z);
                    fail_count++;
                end
                if (got.normal_x != want.normal_x) begin
                    $error("normal_x expected %h actual %h", want.normal_x, got.normal_x);
                    fail_count++;
                end
                if (got.normal_y != want.normal_y) begin
                    $error("normal_y expected %h actual %h", want.normal_y, got.normal_y);
                    fail_count++;
                end
                if (got.normal_z != want.normal_z) begin
                    $error("normal_z expected %h actual %h", want.normal_z, got.normal_z);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: end the run if the cycle budget runs out
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("levelset_edge_crossing_hermite_top_tb failed");
            $finish;
        end
    end

    initial begin
        cycle_count   = 0;
        fail_count    = 0;
        edges_sent    = 0;
        hermites_seen = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_ORIGIN_X;
        i_cfg_data    = '0;
        edge_ch.valid = 1'b0;
        {edge_ch.cell_i, edge_ch.cell_j, edge_ch.cell_k, edge_ch.edge_axis} = '0;
        {edge_ch.level_here, edge_ch.level_next} = '0;
        {edge_ch.grad_here_x, edge_ch.grad_here_y, edge_ch.grad_here_z} = '0;
        {edge_ch.grad_next_x, edge_ch.grad_next_y, edge_ch.grad_next_z} = '0;
        for (int a = 0; a < 3; a++) begin
            origin_sh[a]  = '0;
            spacing_sh[a] = 31'd65536;
        end
        build_table();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at reset settings, no idling
        run_table(1'b1);
        drain_pipe();

        // Phase 1: sender idles 30 %, receiver 52 %, extreme registers
        send_idle_pct = 30;
        recv_idle_pct = 52;
        write_reg(CFG_ORIGIN_X, 32'h7FFF_FFFF);
        write_reg(CFG_ORIGIN_Y, 32'h8000_0000);
        write_reg(CFG_ORIGIN_Z, 32'h0000_0000);
        write_reg(CFG_SPACING_X, 32'h7FFF_FFFF);
        write_reg(CFG_SPACING_Y, 32'h0000_0001);
        write_reg(CFG_SPACING_Z, 32'h0000_0000);
        run_table(1'b0);
        random_burst(N_RANDOM / 4);
        drain_pipe();

        // Phase 2: roles swapped, random registers
        send_idle_pct = 52;
        recv_idle_pct = 30;
        write_reg(CFG_ORIGIN_X, $urandom);
        write_reg(CFG_ORIGIN_Y, $urandom);
        write_reg(CFG_ORIGIN_Z, $urandom);
        write_reg(CFG_SPACING_X, $urandom_range(1, 32'h0004_0000));
        write_reg(CFG_SPACING_Y, $urandom);
        write_reg(CFG_SPACING_Z, $urandom_range(1, 32'h0004_0000));
        random_burst(N_RANDOM / 4);
        drain_pipe();

        // Phase 3: no idling, small negative origin x, extreme y/z, spacing 0.5 on x/y, max on z
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_ORIGIN_X, 32'hFFF8_0000);
        write_reg(CFG_ORIGIN_Y, 32'h8000_0000);
        write_reg(CFG_ORIGIN_Z, 32'h7FFF_FFFF);
        write_reg(CFG_SPACING_X, 32'h0000_8000);
        write_reg(CFG_SPACING_Y, 32'h0000_8000);
        write_reg(CFG_SPACING_Z, 32'h7FFF_FFFF);
        random_burst(N_RANDOM / 2);
        drain_pipe();

        $display("covered %0d edges and %0d Hermite samples over four register settings",
                 edges_sent, hermites_seen);
        $display("idling: sender and receiver stalled in turn, then full rate");
        if (fail_count == 0 && hermite_expected.size() == 0) begin
            $display("levelset_edge_crossing_hermite_top_tb passed");
        end else begin
            $display("levelset_edge_crossing_hermite_top_tb failed");
        end
        $finish;
    end

endmodule
